FILE: src/kpd_pkg.sv
// kpd_pkg: shared types and constants for the kermit packet deframer
// no dependencies; imported by the step logic, the top level and the checker
package kpd_pkg;

  localparam logic [7:0] SOH_MARK   = 8'h01;
  localparam logic [7:0] END_BYTE   = 8'h0D;
  localparam logic [7:0] LEN_MIN    = 8'd35;
  localparam logic [7:0] LEN_MAX    = 8'd126;
  localparam logic [7:0] LEN_BIAS   = 8'd35;
  localparam logic [7:0] CHAR_BIAS  = 8'd32;

  typedef enum logic [2:0] {
    PH_MARK  = 3'd0,
    PH_LEN   = 3'd1,
    PH_SEQ   = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5,
    PH_END   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DATA   = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_REJECT = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_LENGTH   = 3'd1,
    CAUSE_NONASCII = 3'd2,
    CAUSE_CHECKSUM = 3'd3,
    CAUSE_END      = 3'd4
  } cause_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] running_sum;
    logic [6:0] data_count;
    logic [6:0] data_length;
    logic [6:0] held_type;
    logic [6:0] held_seq;
    logic       check_good;
  } state_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic [6:0] packet_type;
    logic [6:0] packet_seq;
    logic [6:0] payload_length;
    cause_t     error_cause;
  } result_t;

endpackage

FILE: src/kpd_stream_if.sv
// kpd_in_if and kpd_out_if: valid/ready channels of the deframer
// no dependencies
interface kpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] data_byte;
  logic [6:0] data_index;
  logic [6:0] packet_type;
  logic [6:0] packet_seq;
  logic [6:0] payload_length;
  logic [2:0] error_cause;

  modport source (output valid, output event_res, output data_byte, output data_index,
                  output packet_type, output packet_seq, output payload_length,
                  output error_cause, input ready);
  modport sink   (input valid, input event_res, input data_byte, input data_index,
                  input packet_type, input packet_seq, input payload_length,
                  input error_cause, output ready);
endinterface

FILE: src/kermit_packet_deframer.sv
// kermit packet deframer, top level: state register and two-entry result buffer
// depends on kpd_pkg, kpd_stream_if and kpd_step
//
// Takes one received byte per item on in_ch and returns exactly one result item
// on out_ch for each, in order. The packet state is a single register updated
// from the byte through kpd_step, so a byte can be accepted in every cycle
// unless both result entries are full, when the input stalls. Results go into an
// output register backed by one skid entry; an accepted byte's result lands in
// the output register, or in the skid entry while the output register stalls.
// After reset the block hunts for SOH; there is no clearing pass.
module kermit_packet_deframer
  import kpd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  kpd_in_if.sink   in_ch,
  kpd_out_if.source out_ch
);

  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t main_res;
  result_t skid_res;
  logic    main_valid;
  logic    skid_valid;
  logic    accept;
  logic    take;

  kpd_step u_step (
    .cur     (st),
    .rx_byte (in_ch.rx_byte),
    .nxt     (st_next),
    .res     (res_next)
  );

  assign in_ch.ready = !skid_valid;
  assign accept      = in_ch.valid && !skid_valid;
  assign take        = main_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_MARK;
      st.running_sum <= 8'd0;
      st.data_count  <= 7'd0;
      st.data_length <= 7'd0;
      st.held_type   <= 7'd0;
      st.held_seq    <= 7'd0;
      st.check_good  <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // control of the output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || take) begin
      main_res <= skid_valid ? skid_res : res_next;
    end
    if (main_valid && !take && accept) begin
      skid_res <= res_next;
    end
  end

  assign out_ch.valid          = main_valid;
  assign out_ch.event_res      = main_res.event_res;
  assign out_ch.data_byte      = main_res.data_byte;
  assign out_ch.data_index     = main_res.data_index;
  assign out_ch.packet_type    = main_res.packet_type;
  assign out_ch.packet_seq     = main_res.packet_seq;
  assign out_ch.payload_length = main_res.payload_length;
  assign out_ch.error_cause    = main_res.error_cause;

endmodule

FILE: src/kpd_step.sv
// kpd_step: next state and result for one received byte
// depends on kpd_pkg
module kpd_step
  import kpd_pkg::*;
(
  input  state_t     cur,
  input  logic [7:0] rx_byte,
  output state_t     nxt,
  output result_t    res
);

  logic [6:0] count_inc;
  logic [5:0] fold;
  event_t     ev;
  cause_t     cause;
  logic [7:0] dbyte;
  logic [6:0] dindex;

  assign count_inc = cur.data_count + 7'd1;
  // type-1 checksum: fold the top two bits back into the low six
  assign fold = cur.running_sum[5:0] + {4'b0000, cur.running_sum[7:6]};

  always_comb begin
    nxt    = cur;
    ev     = EV_NONE;
    cause  = CAUSE_NONE;
    dbyte  = 8'd0;
    dindex = 7'd0;
    unique case (cur.phase)
      PH_LEN: begin
        nxt.phase = PH_MARK;
        if (rx_byte[7]) begin
          ev    = EV_REJECT;
          cause = CAUSE_NONASCII;
        end else if (rx_byte < LEN_MIN || rx_byte > LEN_MAX) begin
          ev    = EV_REJECT;
          cause = CAUSE_LENGTH;
        end else begin
          nxt.running_sum = cur.running_sum + rx_byte;
          nxt.data_length = 7'(rx_byte - LEN_BIAS);
          nxt.phase       = PH_SEQ;
        end
      end
      PH_SEQ: begin
        nxt.phase = PH_MARK;
        if (rx_byte[7]) begin
          ev    = EV_REJECT;
          cause = CAUSE_NONASCII;
        end else begin
          nxt.running_sum = cur.running_sum + rx_byte;
          // control characters decode as sequence zero
          nxt.held_seq    = (rx_byte < CHAR_BIAS) ? 7'd0 : 7'(rx_byte - CHAR_BIAS);
          nxt.phase       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        nxt.phase = PH_MARK;
        if (rx_byte[7]) begin
          ev    = EV_REJECT;
          cause = CAUSE_NONASCII;
        end else begin
          nxt.running_sum = cur.running_sum + rx_byte;
          nxt.held_type   = rx_byte[6:0];
          nxt.data_count  = 7'd0;
          nxt.phase       = (cur.data_length == 7'd0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        nxt.running_sum = cur.running_sum + rx_byte;
        ev              = EV_DATA;
        dbyte           = rx_byte;
        dindex          = cur.data_count;
        nxt.data_count  = count_inc;
        if (count_inc >= cur.data_length) begin
          nxt.phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        nxt.check_good = (rx_byte == ({2'b00, fold} + CHAR_BIAS));
        nxt.phase      = PH_END;
      end
      PH_END: begin
        nxt.phase = PH_MARK;
        if (rx_byte != END_BYTE) begin
          ev    = EV_REJECT;
          cause = CAUSE_END;
        end else if (!cur.check_good) begin
          ev    = EV_REJECT;
          cause = CAUSE_CHECKSUM;
        end else begin
          ev = EV_ACCEPT;
        end
      end
      default: begin
        // mark hunting, also taken by unused phase codes
        nxt.phase = PH_MARK;
        if (rx_byte == SOH_MARK) begin
          nxt.phase       = PH_LEN;
          nxt.running_sum = 8'd0;
        end
      end
    endcase
  end

  assign res.event_res      = ev;
  assign res.data_byte      = dbyte;
  assign res.data_index     = dindex;
  assign res.packet_type    = nxt.held_type;
  assign res.packet_seq     = nxt.held_seq;
  assign res.payload_length = nxt.data_length;
  assign res.error_cause    = cause;

endmodule

FILE: src/kpd_checker.sv
// kpd_checker: port-level assertions for the deframer, bound to the top level
// depends on kpd_pkg and kermit_packet_deframer
module kpd_checker
  import kpd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_res,
  input logic [7:0] data_byte,
  input logic [6:0] data_index,
  input logic [6:0] payload_length,
  input logic [2:0] error_cause
);

  // a cause is reported exactly with a reject
  a_cause_with_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_res == EV_REJECT) == (error_cause != CAUSE_NONE)))
    else $error("error_cause does not match reject event");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_DATA) |-> (data_byte == 8'd0 && data_index == 7'd0))
    else $error("data fields nonzero outside a payload item");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_DATA) |-> (data_index < payload_length))
    else $error("payload index beyond packet length");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(event_res) && $stable(data_byte)
                                   && $stable(data_index) && $stable(error_cause)))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind kermit_packet_deframer kpd_checker u_kpd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .event_res      (out_ch.event_res),
  .data_byte      (out_ch.data_byte),
  .data_index     (out_ch.data_index),
  .payload_length (out_ch.payload_length),
  .error_cause    (out_ch.error_cause)
);
